### hdl/led_bar_effect_animator_macros.svh
// Shared assertion macros for the bar animator.
`ifndef LED_BAR_EFFECT_ANIMATOR_MACROS_SVH
`define LED_BAR_EFFECT_ANIMATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define LBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define LBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/lba_pkg.sv
package lba_pkg;

  localparam int unsigned LED_COUNT = 5;
  localparam int unsigned PIX_W = 3;
  localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(LED_COUNT - 1);
  localparam logic [PIX_W-1:0] PIX_CENTER = PIX_W'(LED_COUNT / 2);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    MODE_NONE = 3'd0,
    MODE_SOLID = 3'd1,
    MODE_RIPPLE = 3'd2,
    MODE_FLOW = 3'd3,
    MODE_PULSE = 3'd4,
    MODE_RAINBOW = 3'd5
  } effect_mode_t;

  typedef struct packed {
    logic [2:0] mode;
    logic right;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [PIX_W-1:0] cursor;
  } frame_job_t;

endpackage

### hdl/lba_front.sv
module lba_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic cmd,
  input  logic [2:0] effect_kind,
  input  logic flow_right,
  input  logic [7:0] color_red,
  input  logic [7:0] color_green,
  input  logic [7:0] color_blue,
  input  logic [15:0] life_ms,
  input  logic [15:0] interval_ms,
  input  logic [31:0] now_ms,
  input  logic q_full,
  output logic q_push,
  output lba_pkg::frame_job_t q_job
);

  logic effect_active, effect_active_next;
  logic [2:0] effect_mode, effect_mode_next;
  logic moves_right, moves_right_next;
  logic [23:0] base_color, base_color_next;
  logic [15:0] frame_period, frame_period_next;
  logic [31:0] end_time, end_time_next;
  logic [31:0] prev_frame_time, prev_frame_time_next;
  logic [lba_pkg::PIX_W-1:0] phase_cursor, phase_cursor_next;
  logic idle_shown, idle_shown_next;
  logic accept;
  logic [31:0] elapsed;
  logic [lba_pkg::PIX_W-1:0] cursor_inc;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign elapsed = now_ms - prev_frame_time;
  assign cursor_inc = (phase_cursor == lba_pkg::PIX_LAST) ? '0 : phase_cursor + 1'b1;

  always_comb begin
    effect_active_next = effect_active;
    effect_mode_next = effect_mode;
    moves_right_next = moves_right;
    base_color_next = base_color;
    frame_period_next = frame_period;
    end_time_next = end_time;
    prev_frame_time_next = prev_frame_time;
    phase_cursor_next = phase_cursor;
    idle_shown_next = idle_shown;
    q_push = 1'b0;
    q_job = '0;
    if (accept) begin
      if (cmd == lba_pkg::CMD_START) begin
        effect_active_next = 1'b1;
        effect_mode_next = effect_kind;
        moves_right_next = flow_right;
        base_color_next = {color_red, color_green, color_blue};
        end_time_next = now_ms + {16'd0, life_ms};
        frame_period_next = interval_ms;
        prev_frame_time_next = now_ms;
        phase_cursor_next = '0;
        idle_shown_next = 1'b0;
        q_push = 1'b1;
        q_job = '{mode: effect_kind, right: flow_right, red: color_red,
                  green: color_green, blue: color_blue, cursor: '0};
      end else if (effect_active && (now_ms < end_time)) begin
        if ((frame_period != 16'd0) && (elapsed >= {16'd0, frame_period})) begin
          prev_frame_time_next = now_ms;
          phase_cursor_next = cursor_inc;
          idle_shown_next = 1'b0;
          q_push = 1'b1;
          q_job = '{mode: effect_mode, right: moves_right, red: base_color[23:16],
                    green: base_color[15:8], blue: base_color[7:0], cursor: cursor_inc};
        end
      end else begin
        effect_active_next = 1'b0;
        effect_mode_next = '0;
        moves_right_next = 1'b0;
        base_color_next = '0;
        frame_period_next = '0;
        if (!idle_shown) begin
          idle_shown_next = 1'b1;
          q_push = 1'b1;
          q_job = '{mode: lba_pkg::MODE_NONE, right: 1'b0, red: 8'd0,
                    green: 8'd0, blue: 8'd0, cursor: '0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_active <= 1'b0;
      effect_mode <= '0;
      moves_right <= 1'b0;
      base_color <= '0;
      frame_period <= '0;
      end_time <= '0;
      prev_frame_time <= '0;
      phase_cursor <= '0;
      idle_shown <= 1'b1;
    end else begin
      effect_active <= effect_active_next;
      effect_mode <= effect_mode_next;
      moves_right <= moves_right_next;
      base_color <= base_color_next;
      frame_period <= frame_period_next;
      end_time <= end_time_next;
      prev_frame_time <= prev_frame_time_next;
      phase_cursor <= phase_cursor_next;
      idle_shown <= idle_shown_next;
    end
  end

endmodule

### hdl/lba_queue.sv
`include "led_bar_effect_animator_macros.svh"

module lba_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  lba_pkg::frame_job_t push_job,
  output logic full,
  output logic head_valid,
  output lba_pkg::frame_job_t head_job,
  input  logic pop
);

  lba_pkg::frame_job_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `LBA_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "push into full queue")
  `LBA_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, head_valid, "pop from empty queue")

endmodule

### hdl/lba_back.sv
`include "led_bar_effect_animator_macros.svh"

module lba_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  lba_pkg::frame_job_t job,
  output logic job_pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] pixel_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic frame_last
);

  localparam logic [16:0] F_FULL = 17'd65536;

  localparam logic [16:0] RIPPLE_F [4][5] = '{
    '{17'd0, 17'd13108, 17'd65536, 17'd13108, 17'd0},
    '{17'd16384, 17'd65536, 17'd32768, 17'd65536, 17'd16384},
    '{17'd65536, 17'd16384, 17'd0, 17'd16384, 17'd65536},
    '{17'd16384, 17'd10923, 17'd8192, 17'd10923, 17'd16384}
  };
  localparam logic [16:0] FLOW_F [5] = '{
    17'd65536, 17'd38230, 17'd21846, 17'd10923, 17'd5462
  };
  localparam logic [16:0] PULSE_CENTER_F [5] = '{
    17'd27307, 17'd65536, 17'd38230, 17'd16384, 17'd5462
  };
  localparam logic [16:0] PULSE_SIDE_F [5] = '{
    17'd16384, 17'd43691, 17'd21846, 17'd10923, 17'd0
  };
  localparam logic [7:0] RAINBOW [7][3] = '{
    '{8'd46, 8'd0, 8'd5}, '{8'd46, 8'd17, 8'd0}, '{8'd38, 8'd35, 8'd0},
    '{8'd0, 8'd43, 8'd11}, '{8'd0, 8'd36, 8'd43}, '{8'd12, 8'd0, 8'd47},
    '{8'd42, 8'd0, 8'd36}
  };

  logic [lba_pkg::PIX_W-1:0] pix;
  logic load;
  logic [3:0] dist_sum;
  logic [lba_pkg::PIX_W-1:0] flow_pos;
  logic [3:0] rb_sum;
  logic [2:0] rb_idx;
  logic [16:0] factor;
  logic [24:0] prod_r, prod_g, prod_b;
  logic [7:0] red_next, green_next, blue_next;

  assign load = job_valid && (!out_valid || out_ready);
  assign job_pop = load && (pix == lba_pkg::PIX_LAST);

  always_comb begin
    if (job.right) begin
      dist_sum = {1'b0, job.cursor} + 4'd5 - {1'b0, pix};
    end else begin
      dist_sum = {1'b0, pix} + {1'b0, job.cursor} + 4'd1;
    end
    flow_pos = (dist_sum >= 4'd5) ? lba_pkg::PIX_W'(dist_sum - 4'd5)
                                  : lba_pkg::PIX_W'(dist_sum);
    rb_sum = {1'b0, pix} + {1'b0, job.cursor};
    rb_idx = (rb_sum >= 4'd7) ? 3'(rb_sum - 4'd7) : 3'(rb_sum);
  end

  always_comb begin
    unique case (job.mode)
      lba_pkg::MODE_SOLID: factor = F_FULL;
      lba_pkg::MODE_RIPPLE: factor = RIPPLE_F[job.cursor[1:0]][pix];
      lba_pkg::MODE_FLOW: factor = FLOW_F[flow_pos];
      lba_pkg::MODE_PULSE: begin
        factor = (pix == lba_pkg::PIX_CENTER) ? PULSE_CENTER_F[job.cursor]
                                              : PULSE_SIDE_F[job.cursor];
      end
      default: factor = '0;
    endcase
  end

  assign prod_r = job.red * factor;
  assign prod_g = job.green * factor;
  assign prod_b = job.blue * factor;

  always_comb begin
    if (job.mode == lba_pkg::MODE_RAINBOW) begin
      red_next = RAINBOW[rb_idx][0];
      green_next = RAINBOW[rb_idx][1];
      blue_next = RAINBOW[rb_idx][2];
    end else begin
      red_next = prod_r[23:16];
      green_next = prod_g[23:16];
      blue_next = prod_b[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pix <= (pix == lba_pkg::PIX_LAST) ? '0 : pix + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_index <= pix;
      out_red <= red_next;
      out_green <= green_next;
      out_blue <= blue_next;
      frame_last <= (pix == lba_pkg::PIX_LAST);
    end
  end

  `LBA_ASSERT_NOW(a_last_on_final, clk, rst, out_valid,
    frame_last == (pixel_index == lba_pkg::PIX_LAST), "frame_last off final pixel")
  `LBA_ASSERT_NEXT(a_frame_contiguous, clk, rst, out_valid && out_ready && !frame_last,
    out_valid && (pixel_index == $past(pixel_index) + 3'd1), "frame broken mid-way")

endmodule

### hdl/led_bar_effect_animator.sv
// A start, or a tick that renders a frame, is written into the job queue and then into the
// pixel engine's output registers before its first pixel is presented; its five pixels follow
// one a cycle while out_ready holds high.
// A rendered frame holds the pixel engine until its five pixels are taken; items that render
// nothing never reach the queue. Input stalls only when the 2-entry job queue is full.
// Reset: rst, synchronous, clears the effect state and queue and marks the bar idle-shown.
module led_bar_effect_animator (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic cmd,
  input  logic [2:0] effect_kind,
  input  logic flow_right,
  input  logic [7:0] color_red,
  input  logic [7:0] color_green,
  input  logic [7:0] color_blue,
  input  logic [15:0] life_ms,
  input  logic [15:0] interval_ms,
  input  logic [31:0] now_ms,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] pixel_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic frame_last
);

  logic q_full;
  logic q_push;
  lba_pkg::frame_job_t q_job;
  logic head_valid;
  lba_pkg::frame_job_t head_job;
  logic head_pop;

  lba_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .effect_kind(effect_kind),
    .flow_right(flow_right),
    .color_red(color_red),
    .color_green(color_green),
    .color_blue(color_blue),
    .life_ms(life_ms),
    .interval_ms(interval_ms),
    .now_ms(now_ms),
    .q_full(q_full),
    .q_push(q_push),
    .q_job(q_job)
  );

  lba_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_job(q_job),
    .full(q_full),
    .head_valid(head_valid),
    .head_job(head_job),
    .pop(head_pop)
  );

  lba_back u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(head_valid),
    .job(head_job),
    .job_pop(head_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_index(pixel_index),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .frame_last(frame_last)
  );

endmodule

### bench/led_bar_effect_animator_test.sv
`timescale 1ns / 100ps

module led_bar_effect_animator_test;

  typedef struct packed {
    logic cmd;
    logic [2:0] kind;
    logic right;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [15:0] dur;
    logic [15:0] ivl;
    logic [31:0] now;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic last;
  } pixel_t;

  class frame_predictor;
    pixel_t expected_px[$];
    int errors;
    logic active;
    logic right;
    logic idle_shown;
    logic [2:0] mode;
    logic [2:0] cursor;
    logic [7:0] base_r;
    logic [7:0] base_g;
    logic [7:0] base_b;
    logic [15:0] period;
    logic [31:0] end_time;
    logic [31:0] prev_time;
    logic [7:0] flow_w[5] = '{12, 7, 4, 2, 1};
    logic [7:0] pulse_w[5] = '{5, 12, 7, 3, 1};
    logic [7:0] ripple_div[4][5] = '{'{0, 5, 1, 5, 0}, '{4, 1, 2, 1, 4},
                                     '{1, 4, 0, 4, 1}, '{4, 6, 8, 6, 4}};
    logic [7:0] rainbow[7][3] = '{'{46, 0, 5}, '{46, 17, 0}, '{38, 35, 0},
                                  '{0, 43, 11}, '{0, 36, 43}, '{12, 0, 47},
                                  '{42, 0, 36}};

    function new();
      errors = 0;
      active = 1'b0;
      right = 1'b0;
      idle_shown = 1'b1;
      mode = 3'd0;
      cursor = 3'd0;
      base_r = 8'd0;
      base_g = 8'd0;
      base_b = 8'd0;
      period = 16'd0;
      end_time = 32'd0;
      prev_time = 32'd0;
    endfunction

    function logic [7:0] dim(logic [7:0] c, int unsigned num, int unsigned den);
      if (den == 0) return 8'd0;
      return 8'((c * num) / den);
    endfunction

    function void push_frame(bit black);
      int unsigned cur;
      int unsigned num;
      int unsigned den;
      int unsigned head;
      int unsigned flow_pos;
      int unsigned n;
      int unsigned i;
      pixel_t px;
      cur = cursor % lba_pkg::LED_COUNT;
      for (i = 0; i < lba_pkg::LED_COUNT; i++) begin
        num = 0;
        den = 1;
        case (mode)
          lba_pkg::MODE_SOLID: num = 1;
          lba_pkg::MODE_RIPPLE: begin
            den = ripple_div[cur & 3][i];
            num = (den != 0) ? 1 : 0;
          end
          lba_pkg::MODE_FLOW: begin
            head = right ? cur : lba_pkg::LED_COUNT - 1 - cur;
            flow_pos = right ? (head + lba_pkg::LED_COUNT - i) % lba_pkg::LED_COUNT
                             : (i + lba_pkg::LED_COUNT - head) % lba_pkg::LED_COUNT;
            num = flow_w[flow_pos];
            den = 12;
          end
          lba_pkg::MODE_PULSE: begin
            n = pulse_w[cur];
            num = (i == lba_pkg::LED_COUNT / 2) ? n : (n * 2) / 3;
            den = 12;
          end
          default: ;
        endcase
        px.idx = 3'(i);
        px.last = (i == lba_pkg::LED_COUNT - 1);
        if (black) begin
          px.red = 8'd0;
          px.green = 8'd0;
          px.blue = 8'd0;
        end else if (mode == lba_pkg::MODE_RAINBOW) begin
          px.red = rainbow[(i + cur) % 7][0];
          px.green = rainbow[(i + cur) % 7][1];
          px.blue = rainbow[(i + cur) % 7][2];
        end else begin
          px.red = dim(base_r, num, den);
          px.green = dim(base_g, num, den);
          px.blue = dim(base_b, num, den);
        end
        expected_px.push_back(px);
      end
      idle_shown = black;
    endfunction

    function void note_word(cmd_word_t w);
      if (w.cmd == lba_pkg::CMD_START) begin
        active = 1'b1;
        mode = w.kind;
        right = w.right;
        base_r = w.red;
        base_g = w.green;
        base_b = w.blue;
        end_time = w.now + 32'(w.dur);
        period = w.ivl;
        prev_time = w.now;
        cursor = 3'd0;
        push_frame(1'b0);
      end else if (active && w.now < end_time) begin
        if (period != 0 && (w.now - prev_time) >= 32'(period)) begin
          prev_time = w.now;
          cursor = 3'((cursor + 1) % lba_pkg::LED_COUNT);
          push_frame(1'b0);
        end
      end else begin
        active = 1'b0;
        mode = 3'd0;
        right = 1'b0;
        base_r = 8'd0;
        base_g = 8'd0;
        base_b = 8'd0;
        period = 16'd0;
        if (!idle_shown) push_frame(1'b1);
      end
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected word for pixel %0d", got.idx));
        return;
      end
      want = expected_px.pop_front();
      if (got.idx !== want.idx)
        report($sformatf("pixel_index got %0d want %0d", got.idx, want.idx));
      if (got.red !== want.red)
        report($sformatf("pixel %0d out_red got %0d want %0d", want.idx, got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("pixel %0d out_green got %0d want %0d", want.idx, got.green,
                         want.green));
      if (got.blue !== want.blue)
        report($sformatf("pixel %0d out_blue got %0d want %0d", want.idx, got.blue,
                         want.blue));
      if (got.last !== want.last)
        report($sformatf("pixel %0d frame_last got %0b want %0b", want.idx, got.last,
                         want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic cmd;
  logic [2:0] effect_kind;
  logic flow_right;
  logic [7:0] color_red;
  logic [7:0] color_green;
  logic [7:0] color_blue;
  logic [15:0] life_ms;
  logic [15:0] interval_ms;
  logic [31:0] now_ms;
  logic out_valid;
  logic out_ready;
  logic [2:0] pixel_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic frame_last;

  frame_predictor board = new();
  int words_sent = 0;
  int unsigned stall_rate = 3;
  bit calm = 1'b0;

  led_bar_effect_animator u_top (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL led_bar_effect_animator");
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_pixel(pixel_t'{pixel_index, out_red, out_green, out_blue, frame_last});
  end

  function automatic cmd_word_t start_word(logic [2:0] kind, logic right, logic [7:0] r,
                                           logic [7:0] g, logic [7:0] b, logic [15:0] dur,
                                           logic [15:0] ivl, logic [31:0] t);
    cmd_word_t w;
    w.cmd = lba_pkg::CMD_START;
    w.kind = kind;
    w.right = right;
    w.red = r;
    w.green = g;
    w.blue = b;
    w.dur = dur;
    w.ivl = ivl;
    w.now = t;
    return w;
  endfunction

  // ignored fields get random values
  function automatic cmd_word_t tick_word(logic [31:0] t);
    cmd_word_t w;
    w.cmd = lba_pkg::CMD_TICK;
    w.kind = 3'($urandom);
    w.right = 1'($urandom);
    w.red = 8'($urandom);
    w.green = 8'($urandom);
    w.blue = 8'($urandom);
    w.dur = 16'($urandom);
    w.ivl = 16'($urandom);
    w.now = t;
    return w;
  endfunction

  task automatic send_word(cmd_word_t w);
    in_valid <= 1'b1;
    cmd <= w.cmd;
    effect_kind <= w.kind;
    flow_right <= w.right;
    color_red <= w.red;
    color_green <= w.green;
    color_blue <= w.blue;
    life_ms <= w.dur;
    interval_ms <= w.ivl;
    now_ms <= w.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(w);
    words_sent++;
    if (!calm && stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_px.size() != 0) @(posedge clk);
  endtask

  task automatic run_effect();
    logic [31:0] t0;
    logic [31:0] t;
    logic [15:0] dur;
    logic [15:0] ivl;
    int unsigned span;
    t0 = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 400) : $urandom;
    case ($urandom_range(0, 9))
      0: dur = 16'($urandom);
      1: dur = 16'd0;
      default: dur = 16'($urandom_range(5, 200));
    endcase
    case ($urandom_range(0, 9))
      0: ivl = 16'($urandom);
      1: ivl = 16'd0;
      default: ivl = 16'($urandom_range(1, 25));
    endcase
    send_word(start_word(3'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), dur, ivl, t0));
    t = t0;
    span = ivl + ivl / 2 + 2;
    repeat ($urandom_range(2, 8)) begin
      t = t + $urandom_range(0, span);
      send_word(tick_word(t));
    end
    if ($urandom_range(0, 3) != 0) begin
      send_word(tick_word(t0 + dur + $urandom_range(0, 5)));
      if ($urandom_range(0, 1) == 1) send_word(tick_word(t0 + dur + $urandom_range(6, 50)));
    end
  endtask

  initial begin
    bit drained_mid;
    drained_mid = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= lba_pkg::CMD_TICK;
    effect_kind <= lba_pkg::MODE_NONE;
    flow_right <= 1'b0;
    color_red <= 8'd0;
    color_green <= 8'd0;
    color_blue <= 8'd0;
    life_ms <= 16'd0;
    interval_ms <= 16'd0;
    now_ms <= 32'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_word(tick_word(32'd0));
    send_word(start_word(lba_pkg::MODE_SOLID, 1'b0, 8'hFF, 8'hFF, 8'hFF, 16'd100, 16'd10,
                         32'd1000));
    send_word(tick_word(32'd1005));
    send_word(tick_word(32'd1010));
    send_word(start_word(lba_pkg::MODE_RIPPLE, 1'b1, 8'hFF, 8'h80, 8'h01, 16'hFFFF, 16'd1,
                         32'd2000));
    send_word(tick_word(32'd2001));
    send_word(tick_word(32'd2002));
    send_word(tick_word(32'd2003));
    send_word(tick_word(32'd2004));
    send_word(start_word(lba_pkg::MODE_FLOW, 1'b1, 8'hAA, 8'h55, 8'hFF, 16'd50, 16'd2,
                         32'd3000));
    send_word(tick_word(32'd3002));
    send_word(start_word(lba_pkg::MODE_FLOW, 1'b0, 8'h7F, 8'hFE, 8'h01, 16'd50, 16'd2,
                         32'd4000));
    send_word(tick_word(32'd4002));
    send_word(start_word(lba_pkg::MODE_PULSE, 1'b0, 8'hFF, 8'hFF, 8'hFF, 16'd30, 16'd3,
                         32'd5000));
    send_word(tick_word(32'd5003));
    send_word(tick_word(32'd5006));
    send_word(start_word(lba_pkg::MODE_RAINBOW, 1'b0, 8'h12, 8'h34, 8'h56, 16'd20, 16'd1,
                         32'd6000));
    send_word(tick_word(32'd6001));
    send_word(start_word(lba_pkg::MODE_NONE, 1'b1, 8'hFF, 8'hFF, 8'hFF, 16'd0, 16'd0,
                         32'd6500));
    send_word(start_word(3'd7, 1'b1, 8'hFF, 8'h00, 8'hFF, 16'd0, 16'd0, 32'd7000));
    send_word(tick_word(32'd7000));
    send_word(tick_word(32'd7001));
    send_word(start_word(3'd6, 1'b0, 8'h0F, 8'hF0, 8'h3C, 16'd100, 16'd0, 32'd8000));
    send_word(tick_word(32'd8050));
    send_word(start_word(lba_pkg::MODE_SOLID, 1'b0, 8'h01, 8'h02, 8'h03, 16'h0020, 16'd1,
                         32'hFFFF_FFF0));
    send_word(tick_word(32'hFFFF_FFF5));
    send_word(tick_word(32'hFFFF_FFF6));
    hold_until_drained();

    while (words_sent < 255) begin
      if (words_sent > 215) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: stall_rate = 0;
        1: stall_rate = 3;
        default: stall_rate = 8;
      endcase
      if (!drained_mid && words_sent > 150) begin
        hold_until_drained();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 6) != 0) begin
        run_effect();
      end else if ($urandom_range(0, 1) == 1) begin
        send_word(tick_word($urandom));
      end else begin
        send_word(start_word(3'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom), 16'($urandom), $urandom));
      end
    end

    hold_until_drained();
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS led_bar_effect_animator");
    end else begin
      $display("FAIL led_bar_effect_animator");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/lba_pkg.sv
hdl/lba_front.sv
hdl/lba_queue.sv
hdl/lba_back.sv
hdl/led_bar_effect_animator.sv
bench/led_bar_effect_animator_test.sv
